// ===== hw/rtl/csvt_pkg.sv =====
// Package with the shared constants and types of the CSV byte tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

  // Character codes the tokenizer reacts to.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Token kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes carried with KIND_ERROR.
  localparam logic [1:0] ERR_STRAY  = 2'd0;
  localparam logic [1:0] ERR_UNTERM = 2'd1;
  localparam logic [1:0] ERR_ROWS   = 2'd2;

  // Row limit register.
  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // Single-bit parser flags.
  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic field_has_chars;
    logic row_has_separator;
    logic failed;
  } csvt_flags_t;

  // One token as produced by the step logic.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [1:0] error_code;
  } csvt_token_t;

endpackage

// ===== hw/rtl/csvt_if.sv =====
// Valid/ready channel interfaces for the input bytes and the output tokens.
`timescale 1ns / 1ps

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic [1:0] error_code;

  modport source (output valid, output kind, output char_out, output error_code, input ready);
  modport sink (input valid, input kind, input char_out, input error_code, output ready);
endinterface

// ===== hw/rtl/csvt_step.sv =====
// Combinational next-state and token logic for one input word.
`timescale 1ns / 1ps

module csvt_step import csvt_pkg::*; #(
  parameter int ROW_COUNT_BITS = 16
) (
  input  csvt_flags_t               flags,
  input  logic [ROW_COUNT_BITS-1:0] rows_seen,
  input  logic [LIMIT_W-1:0]        row_limit,
  input  logic                      cmd,
  input  logic [7:0]                data_byte,
  output csvt_flags_t               flags_nxt,
  output logic [ROW_COUNT_BITS-1:0] rows_seen_nxt,
  output csvt_token_t               token
);

  logic                      blank;
  logic [ROW_COUNT_BITS-1:0] rows_inc;
  logic                      over_limit;
  logic                      unquoted;

  // Row close bookkeeping; the counter saturates at its largest value.
  assign blank    = !flags.field_has_chars && !flags.row_has_separator;
  assign rows_inc = (rows_seen != {ROW_COUNT_BITS{1'b1}}) ?
                    rows_seen + 1'b1 : rows_seen;
  assign over_limit = {{LIMIT_W{1'b0}}, rows_inc} >
                      {{ROW_COUNT_BITS{1'b0}}, row_limit};

  always_comb begin
    flags_nxt        = flags;
    rows_seen_nxt    = rows_seen;
    token.valid      = 1'b0;
    token.kind       = KIND_CHAR;
    token.char_out   = 8'h00;
    token.error_code = ERR_STRAY;
    unquoted         = 1'b0;

    if (cmd) begin
      // End of content: flush the last row or report an open quote, then return to the reset state.
      if (!flags.failed) begin
        if (flags.inside_quotes && !flags.quote_pending) begin
          token.valid      = 1'b1;
          token.kind       = KIND_ERROR;
          token.error_code = ERR_UNTERM;
        end else if (!blank) begin
          token.valid = 1'b1;
          if (over_limit) begin
            token.kind       = KIND_ERROR;
            token.error_code = ERR_ROWS;
          end else begin
            token.kind = KIND_ROW;
          end
        end
      end
      flags_nxt     = '0;
      rows_seen_nxt = '0;
    end else if (!flags.failed) begin
      if (flags.inside_quotes) begin
        if (flags.quote_pending) begin
          flags_nxt.quote_pending = 1'b0;
          if (data_byte == CH_QUOTE) begin
            // Doubled quote stands for one quote character.
            flags_nxt.field_has_chars = 1'b1;
            token.valid    = 1'b1;
            token.kind     = KIND_CHAR;
            token.char_out = CH_QUOTE;
          end else begin
            // The pending quote closed the field; handle this byte unquoted.
            flags_nxt.inside_quotes = 1'b0;
            unquoted = 1'b1;
          end
        end else if (data_byte == CH_QUOTE) begin
          flags_nxt.quote_pending = 1'b1;
        end else begin
          flags_nxt.field_has_chars = 1'b1;
          token.valid    = 1'b1;
          token.kind     = KIND_CHAR;
          token.char_out = data_byte;
        end
      end else begin
        unquoted = 1'b1;
      end

      if (unquoted) begin
        if (data_byte == CH_QUOTE) begin
          if (flags.field_has_chars) begin
            flags_nxt.failed = 1'b1;
            token.valid      = 1'b1;
            token.kind       = KIND_ERROR;
            token.error_code = ERR_STRAY;
          end else begin
            flags_nxt.inside_quotes = 1'b1;
          end
        end else if (data_byte == CH_COMMA) begin
          flags_nxt.row_has_separator = 1'b1;
          flags_nxt.field_has_chars   = 1'b0;
          token.valid = 1'b1;
          token.kind  = KIND_FIELD;
        end else if (data_byte == CH_CR || data_byte == CH_LF) begin
          flags_nxt.field_has_chars   = 1'b0;
          flags_nxt.row_has_separator = 1'b0;
          if (!blank) begin
            rows_seen_nxt = rows_inc;
            token.valid   = 1'b1;
            if (over_limit) begin
              flags_nxt.failed = 1'b1;
              token.kind       = KIND_ERROR;
              token.error_code = ERR_ROWS;
            end else begin
              token.kind = KIND_ROW;
            end
          end
        end else begin
          flags_nxt.field_has_chars = 1'b1;
          token.valid    = 1'b1;
          token.kind     = KIND_CHAR;
          token.char_out = data_byte;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/csv_byte_tokenizer.sv =====
// Top level of the streaming CSV byte tokenizer.
`timescale 1ns / 1ps

// The tokenizer takes CSV text one word at a time on in_chan (cmd, data_byte)
// and gives at most one token word per input word on out_chan (kind,
// char_out, error_code). A cmd of one is the end-of-content command: it
// flushes the last row and returns the parser to its reset state.
// The single configuration register, row_limit, is written through cfg_we
// and cfg_wdata; it should only be changed while no word is in flight.
// An accepted word is held in an input register; when the output register
// has room, the step logic updates the parser state and loads the token
// into the output register, which presents it on out_chan until the
// receiver takes it. The block takes one word every cycle while out_chan
// is not stalled; the rate is set by the single parser state update.
// Words that produce no token (an opening quote, a quote held as pending,
// a blank row end, anything after an error) simply leave no output word.
// A synchronous reset clears the parser state and both registers and sets
// row_limit to 65535. When the receiver holds out_chan.ready low, the
// output register keeps its token, the input register fills and then
// in_chan.ready drops; nothing is lost or repeated.
module csv_byte_tokenizer import csvt_pkg::*; #(
  parameter int ROW_COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  csvt_in_if.sink            in_chan,
  csvt_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  // Configuration.
  logic [LIMIT_W-1:0] row_limit_r;

  // Input register stage.
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;

  // Parser state.
  csvt_flags_t               flags_r;
  csvt_flags_t               flags_nxt;
  logic [ROW_COUNT_BITS-1:0] rows_seen_r;
  logic [ROW_COUNT_BITS-1:0] rows_seen_nxt;

  // Output register stage.
  csvt_token_t token;
  csvt_token_t out_tok_r;

  logic out_free;
  logic s1_adv;
  logic in_fire;

  // The output register can take a new word when it is empty or being drained.
  assign out_free = !out_tok_r.valid || out_chan.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_fire  = in_chan.valid && in_chan.ready;

  csvt_step #(
    .ROW_COUNT_BITS(ROW_COUNT_BITS)
  ) u_step (
    .flags        (flags_r),
    .rows_seen    (rows_seen_r),
    .row_limit    (row_limit_r),
    .cmd          (s1_cmd_r),
    .data_byte    (s1_byte_r),
    .flags_nxt    (flags_nxt),
    .rows_seen_nxt(rows_seen_nxt),
    .token        (token)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      row_limit_r <= cfg_wdata;
    end
  end

  // Input register: a word moves on whenever the output side has room.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_chan.cmd;
      s1_byte_r <= in_chan.data_byte;
    end
  end

  // Parser state advances once per word leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      rows_seen_r <= '0;
    end else if (s1_adv) begin
      flags_r     <= flags_nxt;
      rows_seen_r <= rows_seen_nxt;
    end
  end

  // Output register; a word with no token leaves it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tok_r.valid <= 1'b0;
    end else if (s1_adv) begin
      out_tok_r.valid <= token.valid;
    end else if (out_chan.ready) begin
      out_tok_r.valid <= 1'b0;
    end
    if (s1_adv) begin
      out_tok_r.kind       <= token.kind;
      out_tok_r.char_out   <= token.char_out;
      out_tok_r.error_code <= token.error_code;
    end
  end

  assign out_chan.valid      = out_tok_r.valid;
  assign out_chan.kind       = out_tok_r.kind;
  assign out_chan.char_out   = out_tok_r.char_out;
  assign out_chan.error_code = out_tok_r.error_code;

  // A quote can only be pending while the parser is inside quotes.
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.quote_pending |-> flags_r.inside_quotes)
    else $error("quote pending outside quotes");

  // The end command always leaves the parser in its cleared state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r) |=> (flags_r == '0 && rows_seen_r == '0))
    else $error("end command did not clear the parser state");

  // An error token from a content byte makes the parser sticky-failed.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_cmd_r && token.valid && token.kind == KIND_ERROR)
      |=> flags_r.failed)
    else $error("error token without failed state");

  // A failed parser gives no token for a content byte.
  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_cmd_r && flags_r.failed) |=> !out_tok_r.valid)
    else $error("token emitted while failed");

endmodule

// ===== tb/csv_byte_tokenizer_tb.sv =====
// Self-checking testbench for the CSV byte tokenizer: directed rows, short rows, random CSV.
`timescale 1ns / 1ps

// The testbench drives words of CSV content into the tokenizer and checks
// every token word that comes out. It does this with its own model of the
// parser. That model runs in step with the input side: each time a word is
// accepted, the model works out the token that the word must cause, if any,
// and queues it. The output side pops the oldest queued token for every
// token word it accepts and compares the three fields.
//
// The run has three parts.
// 1. A short table of hand-picked words. It covers the byte extremes, each
//    token kind and each error. It also covers quotes held pending, blank
//    CRLF rows, a quote that closes at the end command, and row limits of
//    zero and one. Where a row's token is obvious at a glance, the table
//    gives it directly in place of the model's; the model advances on every row.
// 2. A run of short rows at the largest row limit. None of them may be
//    reported as one too many.
// 3. Random phases. Mostly these are well-formed CSV documents with random
//    content, quoted fields, doubled quotes and mixed row ends. Noise,
//    stray quotes and unterminated quotes are mixed in. Each phase uses its
//    own row limit and its own idling pattern. One phase holds the
//    receiver off for a long stretch, so the block fills up and stalls
//    its input.
module csv_byte_tokenizer_tb;
  import csvt_pkg::*;

  localparam int ROW_BITS      = 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PIPE_SETTLE   = 4;       // a token is loaded after its word passes the input register
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_WORDS   = 300;
  localparam int COUNTER_ROWS  = 40;
  localparam int REPORT_MAX    = 10;

  // A token with no error attached carries a zero code.
  localparam logic [1:0] NO_CODE = 2'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [1:0] code;
  } token_t;

  localparam token_t NO_TOKEN = '0;

  typedef enum logic [1:0] {DIR_BYTE, DIR_END, DIR_LIMIT} dir_op_t;

  // One row of the directed table. For DIR_LIMIT, value holds the new row
  // limit; otherwise its low byte is the data byte of the word. When typed is
  // set, has_tok and tok are the expected outcome as written in the table.
  typedef struct packed {
    dir_op_t     op;
    logic [15:0] value;
    logic        typed;
    logic        has_tok;
    token_t      tok;
  } dir_row_t;

  localparam int DIR_ROWS = 31;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{DIR_BYTE,  16'h0000,           1'b1, 1'b1, '{KIND_CHAR, 8'h00, NO_CODE}},
    '{DIR_BYTE,  16'h00FF,           1'b1, 1'b1, '{KIND_CHAR, 8'hFF, NO_CODE}},
    '{DIR_BYTE,  {8'h00, CH_COMMA},  1'b1, 1'b1, '{KIND_FIELD, 8'h00, NO_CODE}},
    // A quoted field with a comma, an LF, a doubled quote and a closing
    // quote. The closing quote waits until the CR that follows it.
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_COMMA},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_LF},     1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_CR},     1'b0, 1'b0, NO_TOKEN},
    // The LF of the CRLF closes a blank row and gives nothing.
    '{DIR_BYTE,  {8'h00, CH_LF},     1'b0, 1'b0, NO_TOKEN},
    // A stray quote after a character, then a byte ignored while failed.
    '{DIR_BYTE,  16'h0078,           1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b1, 1'b1, '{KIND_ERROR, 8'h00, ERR_STRAY}},
    '{DIR_BYTE,  16'h0041,           1'b1, 1'b0, NO_TOKEN},
    '{DIR_END,   16'h00A5,           1'b1, 1'b0, NO_TOKEN},
    // An open quote at the end command.
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  16'h007A,           1'b0, 1'b0, NO_TOKEN},
    '{DIR_END,   16'h005A,           1'b1, 1'b1, '{KIND_ERROR, 8'h00, ERR_UNTERM}},
    // A quote still pending at the end command closes the field normally.
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  16'h0071,           1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_QUOTE},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_END,   16'h0000,           1'b0, 1'b0, NO_TOKEN},
    // With a limit of zero, every non-blank row is one too many.
    '{DIR_LIMIT, 16'h0000,           1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_COMMA},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_LF},     1'b1, 1'b1, '{KIND_ERROR, 8'h00, ERR_ROWS}},
    '{DIR_END,   16'h00FF,           1'b1, 1'b0, NO_TOKEN},
    // With a limit of one, the second row fails when the end command flushes it.
    '{DIR_LIMIT, 16'h0001,           1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  16'h0061,           1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_CR},     1'b0, 1'b0, NO_TOKEN},
    '{DIR_BYTE,  {8'h00, CH_COMMA},  1'b0, 1'b0, NO_TOKEN},
    '{DIR_END,   16'h0080,           1'b1, 1'b1, '{KIND_ERROR, 8'h00, ERR_ROWS}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  csv_byte_tokenizer #(.ROW_COUNT_BITS(ROW_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Parser model state. It mirrors the block's state after reset.
  logic                 quoted_now     = 1'b0;
  logic                 quote_held     = 1'b0;
  logic                 field_has_data = 1'b0;
  logic                 row_has_comma  = 1'b0;
  logic [ROW_BITS-1:0]  rows_counted   = '0;
  logic                 parse_failed   = 1'b0;
  logic [LIMIT_W-1:0]   row_limit_now  = LIMIT_RESET;

  token_t expected_tokens [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int words_sent     = 0;
  int live_words     = 0;   // words the block acted on, rather than ignored after an error
  int tokens_checked = 0;
  int mismatch_count = 0;

  // Closes the current row. A row with no characters and no comma is blank.
  // It gives nothing and is not counted. The row counter stops at its top
  // value rather than wrapping, so a limit at that value can never be passed.
  function automatic logic close_row_token(output token_t t);
    logic blank;
    blank          = !field_has_data && !row_has_comma;
    field_has_data = 1'b0;
    row_has_comma  = 1'b0;
    t = NO_TOKEN;
    if (blank) return 1'b0;
    if (rows_counted != '1) rows_counted++;
    if (rows_counted > row_limit_now) begin
      parse_failed = 1'b1;
      t = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_ROWS};
    end else begin
      t = '{kind: KIND_ROW, ch: 8'h00, code: NO_CODE};
    end
    return 1'b1;
  endfunction

  // Advances the model by one word. Returns whether the word causes a token.
  function automatic logic tokenize_word(input logic is_end, input logic [7:0] b,
                                         output token_t t);
    logic got;
    t = NO_TOKEN;
    got = 1'b0;
    if (is_end) begin
      if (!parse_failed) begin
        if (quoted_now && !quote_held) begin
          t = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_UNTERM};
          got = 1'b1;
        end else begin
          got = close_row_token(t);
        end
      end
      quoted_now     = 1'b0;
      quote_held     = 1'b0;
      field_has_data = 1'b0;
      row_has_comma  = 1'b0;
      rows_counted   = '0;
      parse_failed   = 1'b0;
      return got;
    end
    if (parse_failed) return 1'b0;

    if (quoted_now) begin
      if (quote_held) begin
        // A held quote is either doubled (a data quote) or closes the field.
        // If it closes the field, this byte is handled as unquoted below.
        quote_held = 1'b0;
        if (b == CH_QUOTE) begin
          field_has_data = 1'b1;
          t = '{kind: KIND_CHAR, ch: CH_QUOTE, code: NO_CODE};
          return 1'b1;
        end
        quoted_now = 1'b0;
      end else if (b == CH_QUOTE) begin
        quote_held = 1'b1;
        return 1'b0;
      end else begin
        field_has_data = 1'b1;
        t = '{kind: KIND_CHAR, ch: b, code: NO_CODE};
        return 1'b1;
      end
    end

    if (b == CH_QUOTE) begin
      if (field_has_data) begin
        parse_failed = 1'b1;
        t = '{kind: KIND_ERROR, ch: 8'h00, code: ERR_STRAY};
        return 1'b1;
      end
      quoted_now = 1'b1;
      return 1'b0;
    end
    if (b == CH_COMMA) begin
      row_has_comma  = 1'b1;
      field_has_data = 1'b0;
      t = '{kind: KIND_FIELD, ch: 8'h00, code: NO_CODE};
      return 1'b1;
    end
    if (b == CH_CR || b == CH_LF) return close_row_token(t);
    field_has_data = 1'b1;
    t = '{kind: KIND_CHAR, ch: b, code: NO_CODE};
    return 1'b1;
  endfunction

  function automatic void report_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Offers one word and waits until it is accepted. Then it records the
  // expected token. Valid is only lowered when the sender is going to idle.
  // Back-to-back words therefore keep valid high, and valid never sees two
  // writes in the same time step.
  task automatic send_word(input logic is_end, input logic [7:0] b,
                           input logic typed = 1'b0, input logic typed_has = 1'b0,
                           input token_t typed_tok = NO_TOKEN);
    token_t tok;
    logic   has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= is_end;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (is_end || !parse_failed) live_words++;
    has = tokenize_word(is_end, b, tok);
    if (typed) begin
      has = typed_has;
      tok = typed_tok;
    end
    if (has) expected_tokens.insert(expected_tokens.size(), tok);
    words_sent++;
  endtask

  // The row limit may only change while the block is idle. So the task
  // stops sending and waits for every expected token. Then it goes on
  // waiting, because the last words may have been ones that give no
  // token and could still be in flight.
  task automatic write_row_limit(input logic [LIMIT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_limit_now = value;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  // Any byte. Quotes, commas, CR and LF are drawn more often than chance,
  // at the given percentage.
  function automatic logic [7:0] content_byte(input int special_pct);
    if ($urandom_range(99) >= special_pct) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic send_row_end();
    case ($urandom_range(2))
      0: send_word(1'b0, CH_CR);
      1: send_word(1'b0, CH_LF);
      default: begin
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
      end
    endcase
  endtask

  // One random document, closed by an end command. Most documents are
  // well-formed CSV. Some are pure noise, some contain a stray quote, and
  // some stop inside an open quote or without a final row end.
  task automatic send_document();
    int         rows;
    int         fields;
    int         len;
    logic [7:0] c;
    if ($urandom_range(99) < 12) begin
      len = $urandom_range(4, 30);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 3) send_word(1'b1, 8'($urandom_range(255)));
        else send_word(1'b0, content_byte(40));
      end
      send_word(1'b1, 8'($urandom_range(255)));
      return;
    end

    rows = $urandom_range(1, 6);
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(99) < 8) begin
        send_row_end();
        continue;
      end
      fields = $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
        if (f != 0) send_word(1'b0, CH_COMMA);
        if ($urandom_range(99) < 35) begin
          send_word(1'b0, CH_QUOTE);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) begin
            c = content_byte(30);
            send_word(1'b0, c);
            if (c == CH_QUOTE) send_word(1'b0, CH_QUOTE);
          end
          if (r == rows - 1 && f == fields - 1 && $urandom_range(99) < 10) begin
            send_word(1'b1, 8'($urandom_range(255)));
            return;
          end
          send_word(1'b0, CH_QUOTE);
        end else begin
          len = $urandom_range(0, 6);
          for (int i = 0; i < len; i++) begin
            // Now and then a quote lands inside an unquoted field.
            if ($urandom_range(99) < 2) send_word(1'b0, CH_QUOTE);
            else send_word(1'b0, plain_byte());
          end
        end
      end
      if (r != rows - 1 || $urandom_range(99) < 80) send_row_end();
    end
    send_word(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [LIMIT_W-1:0] limit, input logic hold);
    int target;
    write_row_limit(limit);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) hold_off_left = HOLD_CYCLES;
    target = words_sent + PHASE_WORDS;
    while (words_sent < target) send_document();
  endtask

  // Output side. At each edge it takes a token word if one was accepted,
  // then decides ready for the next cycle. A long hold-off takes priority
  // over the random stalls, and this process counts it down.
  initial begin : token_sink
    token_t got;
    token_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{kind: out_ch.kind, ch: out_ch.char_out, code: out_ch.error_code};
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
          report_failure($sformatf("token kind=%0d char=%02h code=%0d with nothing expected",
                                   got.kind, got.ch, got.code));
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want)
            report_failure($sformatf(
              "expected kind=%0d char=%02h code=%0d, got kind=%0d char=%02h code=%0d",
              want.kind, want.ch, want.code, got.kind, got.ch, got.code));
        end
      end
      if (hold_off_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Cycle counter that ends a run that hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL csv_byte_tokenizer");
    $finish;
  end

  initial begin : stimulus
    int waited;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = LIMIT_RESET;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = 1'b0;
    in_ch.data_byte = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_table[i].op)
        DIR_LIMIT: write_row_limit(dir_table[i].value);
        DIR_END: send_word(1'b1, dir_table[i].value[7:0], dir_table[i].typed,
                           dir_table[i].has_tok, dir_table[i].tok);
        default: send_word(1'b0, dir_table[i].value[7:0], dir_table[i].typed,
                           dir_table[i].has_tok, dir_table[i].tok);
      endcase
    end

    // Two-word rows at the largest limit. No row here may be reported
    // as one too many.
    write_row_limit(LIMIT_RESET);
    for (int r = 0; r < COUNTER_ROWS; r++) begin
      send_word(1'b0, plain_byte());
      send_word(1'b0, $urandom_range(1) ? CH_LF : CH_CR);
    end
    send_word(1'b1, 8'($urandom_range(255)));

    run_phase(0, 0, 16'hFFFF, 1'b0);
    run_phase(64, 0, 16'd3, 1'b0);
    run_phase(0, 64, 16'd1, 1'b0);
    run_phase(35, 35, 16'($urandom_range(2, 8)), 1'b0);
    run_phase(0, 0, 16'd2, 1'b1);

    in_ch.valid <= 1'b0;
    for (waited = 0; waited < DRAIN_LIMIT && expected_tokens.size() != 0; waited++)
      @(posedge clk);
    repeat (PIPE_SETTLE * 2) @(posedge clk);
    if (expected_tokens.size() != 0)
      report_failure($sformatf("%0d expected tokens never arrived", expected_tokens.size()));

    $display("Sent %0d words (%0d acted on rather than ignored after an error), checked %0d tokens,",
             words_sent, live_words, tokens_checked);
    $display("covering directed cases, a run of short rows and five random idling phases.");
    if (mismatch_count == 0) begin
      $display("PASS csv_byte_tokenizer");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL csv_byte_tokenizer");
    end
    $finish;
  end

endmodule
